// ===== sv/bkl_pkg.sv =====
// bkl_pkg: shared types and codes for the bakery ticket lock arbiter
// request/result transaction structs, request kind codes, register reset value
// no dependencies
package bkl_pkg;

  localparam int TICKET_OUT_BITS = 32;

  localparam logic [1:0] REQ_TAKE    = 2'd0;
  localparam logic [1:0] REQ_POLL    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [3:0] ACTIVE_THREADS_RESET = 4'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] thread_id;
  } bkl_in_t;

  typedef struct packed {
    logic                       granted;
    logic [TICKET_OUT_BITS-1:0] ticket;
    logic                       ticket_saturated;
    logic                       bad_thread;
  } bkl_out_t;

endpackage

// ===== sv/bkl_cmp.sv =====
// bkl_cmp: shared ticket comparator used by every scan step
// gives less-than and equal of two unsigned tickets
// no dependencies
module bkl_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt,
  output logic         eq
);

  assign lt = (a < b);
  assign eq = (a == b);

endmodule

// ===== sv/bkl_store.sv =====
// bkl_store: per-thread ticket memory with one write and one registered read port
// entries never written since reset read as zero through per-entry valid bits
// no dependencies
module bkl_store #(
  parameter int DEPTH = 8,
  parameter int W     = 32,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== sv/bakery_ticket_lock_arbiter_top.sv =====
// bakery_ticket_lock_arbiter_top: ticket-ordered lock arbiter (bakery scheme)
// sequencer driving one shared comparator over the ticket store
// depends on bkl_pkg, bkl_cmp, bkl_store
//
//  channel  ports                        handshake
//  -------  ---------------------------  ---------------------------------------
//  request  start, busy, in_data         taken when start high and busy low
//  result   out_valid, out_data          one-cycle strobe, cannot be held off
//  config   cfg_valid, cfg_ready, cfg_data  written when valid and ready high
//
// the scan covers active_threads entries, held to MAX_THREADS
// a bad thread id is answered in the cycle after acceptance and busy never rises
// take ticket: scans the active entries for the maximum, one entry read per cycle
// poll with interest: own ticket read first, then the scan;
//   release, unknown kinds and polls without interest read the own ticket and skip the scan
// the rate is set by the single read port of the ticket store and the shared comparator
// reset is synchronous: interest and store valid bits clear at once, no clearing pass
// the receiver cannot stall, so a result never waits and busy drops as it is shown
module bakery_ticket_lock_arbiter_top #(
  parameter int MAX_THREADS = 8,
  parameter int TICKET_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  bkl_pkg::bkl_in_t in_data,
  output logic             out_valid,
  output bkl_pkg::bkl_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_data
);

  import bkl_pkg::*;

  // index width for the store, count width for thread numbers and the scan counter
  localparam int IDX_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int EW    = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MINE  = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

  logic [2:0]             state_r, state_nxt;
  logic [3:0]             active_r;
  logic [MAX_THREADS-1:0] intr_r, intr_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [IDX_W-1:0]       me_r, me_nxt;
  logic [EW-1:0]          cnt_r, cnt_nxt;
  logic [EW-1:0]          k_r, k_nxt;
  logic                   pend_r, pend_nxt;
  logic [IDX_W-1:0]       idx_d_r, idx_d_nxt;
  logic [TICKET_BITS-1:0] top_r, top_nxt;
  logic [TICKET_BITS-1:0] mine_r, mine_nxt;
  logic                   blocked_r, blocked_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bkl_out_t               out_r, out_nxt;

  // effective thread count and bad-thread check on the incoming request
  logic [EW-1:0]          eff_cnt;
  logic [EW-1:0]          tid_ext;
  logic                   accept;

  // store and comparator hookup
  logic                   wr_en;
  logic [TICKET_BITS-1:0] wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [TICKET_BITS-1:0] rd_data;
  logic [TICKET_BITS-1:0] cmp_b;
  logic                   cmp_lt;
  logic                   cmp_eq;

  // new ticket for a take: maximum plus one, held at the top value
  logic                   sat;
  logic [TICKET_BITS-1:0] new_ticket;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = ~busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign accept  = start & ~busy;
  assign eff_cnt = (EW'(active_r) > EW'(MAX_THREADS)) ? EW'(MAX_THREADS) : EW'(active_r);
  assign tid_ext = EW'(in_data.thread_id);

  assign sat        = (top_r == TICKET_TOP);
  assign new_ticket = sat ? top_r : top_r + 1'b1;

  // comparator reference: running maximum for a take, own ticket for a poll
  assign cmp_b = (kind_r == REQ_TAKE) ? top_r : mine_r;

  bkl_cmp #(
    .W (TICKET_BITS)
  ) u_cmp (
    .a  (rd_data),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  bkl_store #(
    .DEPTH (MAX_THREADS),
    .W     (TICKET_BITS),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (me_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    intr_nxt      = intr_r;
    kind_nxt      = kind_r;
    me_nxt        = me_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    idx_d_nxt     = idx_d_r;
    top_nxt       = top_r;
    mine_nxt      = mine_r;
    blocked_nxt   = blocked_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_data       = new_ticket;
    rd_addr       = me_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt    = in_data.req_type;
          me_nxt      = IDX_W'(tid_ext);
          cnt_nxt     = eff_cnt;
          k_nxt       = '0;
          pend_nxt    = 1'b0;
          top_nxt     = '0;
          blocked_nxt = 1'b0;
          if (tid_ext >= eff_cnt) begin
            // not a participating thread: answer straight away, nothing changes
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.bad_thread = 1'b1;
          end else if (in_data.req_type == REQ_TAKE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_MINE;
          end
        end
      end

      S_MINE: begin
        rd_addr   = me_r;
        state_nxt = S_MWAIT;
      end

      S_MWAIT: begin
        mine_nxt = rd_data;
        if (kind_r == REQ_POLL && intr_r[me_r]) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SCAN: begin
        // evaluate the entry read last cycle
        if (pend_r) begin
          if (kind_r == REQ_TAKE) begin
            if (!cmp_lt && !cmp_eq) begin
              top_nxt = rd_data;
            end
          end else if (idx_d_r != me_r && intr_r[idx_d_r] &&
                       (cmp_lt || (cmp_eq && idx_d_r < me_r))) begin
            blocked_nxt = 1'b1;
          end
        end
        if (k_r < cnt_r) begin
          rd_addr   = IDX_W'(k_r);
          idx_d_nxt = IDX_W'(k_r);
          pend_nxt  = 1'b1;
          k_nxt     = k_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.ticket = TICKET_OUT_BITS'(mine_r);
        case (kind_r)
          REQ_TAKE: begin
            wr_en        = 1'b1;
            intr_nxt[me_r] = 1'b1;
            out_nxt.ticket = TICKET_OUT_BITS'(new_ticket);
            out_nxt.ticket_saturated = sat;
          end
          REQ_POLL: begin
            out_nxt.granted = intr_r[me_r] & ~blocked_r;
          end
          REQ_RELEASE: begin
            intr_nxt[me_r] = 1'b0;
          end
          default: begin
          end
        endcase
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_THREADS_RESET;
      intr_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      intr_r      <= intr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    me_r      <= me_nxt;
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    idx_d_r   <= idx_d_nxt;
    top_r     <= top_nxt;
    mine_r    <= mine_nxt;
    blocked_r <= blocked_nxt;
    out_r     <= out_nxt;
  end

endmodule
